FILE: rtl/ctns_pkg.sv
package ctns_pkg;

   // Shift search starts here and counts down.
   localparam int MAX_SHIFT = 32;

   localparam int KHZ_W   = 24;
   localparam int MUL_W   = 31;
   localparam int SHIFT_W = 6;
   localparam int DATA_W  = 64;
   // khz * 1000 stays below 2^34 for any in-range frequency.
   localparam int DVSR_W  = 34;
   // 10^6 << 32 needs 52 bits and khz << 31 needs 55 bits.
   localparam int CMP_W   = 56;

   localparam logic [KHZ_W-1:0] KHZ_LOW     = 24'd100000;
   localparam logic [KHZ_W-1:0] KHZ_HIGH    = 24'd9999999;
   localparam logic [KHZ_W-1:0] KHZ_DEFAULT = 24'd1000000;

   localparam logic [19:0]      KHZ_NUM    = 20'd1000000;
   localparam logic [MUL_W-1:0] NS_PER_S   = 31'd1000000000;
   localparam logic [9:0]       HZ_PER_KHZ = 10'd1000;

   localparam logic [MUL_W-1:0]   MUL_RESET   = 31'd1073741824;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd30;

   // Serial unit step counts.
   localparam int DIV_STEPS = DATA_W;
   localparam int MUL_STEPS = MUL_W;

   // Configuration register indexes.
   localparam logic REG_COUNTER_KHZ     = 1'b0;
   localparam logic REG_REFERENCE_COUNT = 1'b1;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SEARCH,
      SEQ_DIV_M,
      SEQ_MUL_NS,
      SEQ_DIV_NS,
      SEQ_MUL_OFS,
      SEQ_COMMIT
   } seq_state_type;

endpackage

FILE: rtl/cycles_to_nanoseconds_scaler_top.sv
// Converts raw cycle-counter values into nanoseconds as
// nanoseconds = time_offset + ((cycle_count * multiplier) >> shift), all modulo 2^64.
// The conversion path is a four-stage pipeline (two 32x31 partial products, their sum,
// the shift, the offset add): it takes one item per clock while no derivation is
// running and the output side does not stall, and each item passes the product, sum,
// shift and offset registers in order before rsp_tvalid rises. A stall on the result
// side holds the full stages in place; bubbles are squeezed out as it drains.
// Writing counter_khz (index 0) or reference_count (index 1) restarts a serial derivation
// of multiplier, shift and offset that shares one restoring divider (one quotient bit a
// cycle) and one shift-add multiplier (one multiplier bit a cycle). In order it runs a
// shift search, a division for the multiplier, a multiplication and a division for the
// reference time, a multiplication for the offset and a commit; req_tready stays low
// until it is done. A frequency outside 100000 to 9999999 kHz is treated as 1000000 kHz.
module cycles_to_nanoseconds_scaler_top (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] cycle_count
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] nanoseconds
   // Configuration writes.
   input  logic        csr_wen,
   input  logic        csr_idx,
   input  logic [63:0] csr_wdata
);

   // Configuration and derived scale.
   logic [ctns_pkg::KHZ_W-1:0]   khz_ff, khz_in;
   logic [ctns_pkg::DATA_W-1:0]  ref_ff, ref_in;
   logic [ctns_pkg::MUL_W-1:0]   scale_mul_ff, scale_mul_in;
   logic [ctns_pkg::SHIFT_W-1:0] scale_shift_ff, scale_shift_in;
   logic [ctns_pkg::DATA_W-1:0]  time_offset_ff, time_offset_in;

   // Derivation sequencer.
   ctns_pkg::seq_state_type      seq_state_ff, seq_state_in;
   logic [ctns_pkg::SHIFT_W-1:0] srch_ff, srch_in;
   logic [5:0]                   step_ff, step_in;
   logic [ctns_pkg::DVSR_W-1:0]  rem_ff, rem_in;
   logic [ctns_pkg::DATA_W-1:0]  quo_ff, quo_in;
   logic [ctns_pkg::DVSR_W-1:0]  dvsr_ff, dvsr_in;
   logic [ctns_pkg::DATA_W-1:0]  acc_ff, acc_in;
   logic [ctns_pkg::DATA_W-1:0]  mcand_ff, mcand_in;
   logic [ctns_pkg::MUL_W-1:0]   mplier_ff, mplier_in;
   logic [ctns_pkg::MUL_W-1:0]   wrk_mul_ff, wrk_mul_in;
   logic [ctns_pkg::SHIFT_W-1:0] wrk_shift_ff, wrk_shift_in;

   logic [ctns_pkg::KHZ_W-1:0]   khz_eff;
   logic [ctns_pkg::CMP_W-1:0]   num_shl;
   logic [ctns_pkg::CMP_W-1:0]   khz_lim;
   logic                         shift_fits;
   logic [ctns_pkg::DVSR_W:0]    div_trial;
   logic                         div_ge;
   logic [ctns_pkg::DVSR_W-1:0]  div_rem_next;
   logic [ctns_pkg::DATA_W-1:0]  div_quo_next;
   logic [ctns_pkg::DATA_W-1:0]  mul_acc_next;
   logic [ctns_pkg::DVSR_W-1:0]  ns_divisor;

   // Conversion pipeline.
   logic        v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic [62:0] prod_lo_ff;
   logic [31:0] prod_hi_ff;
   logic [63:0] prod_ff;
   logic [63:0] scaled_ff;
   logic [63:0] rsp_data_ff;
   logic [62:0] prod_lo_full;
   logic [62:0] prod_hi_full;
   logic        adv1, adv2, adv3, adv4;
   logic        req_fire;

   // ------------------------------------------------------------------
   // Derivation datapath.
   // ------------------------------------------------------------------

   // Out-of-range frequencies fall back to 1 GHz.
   assign khz_eff = (khz_ff < ctns_pkg::KHZ_LOW || khz_ff > ctns_pkg::KHZ_HIGH) ?
                    ctns_pkg::KHZ_DEFAULT : khz_ff;

   // floor((10^6 << s) / khz) < 2^31 exactly when 10^6 << s < khz << 31.
   assign num_shl    = ctns_pkg::CMP_W'(ctns_pkg::KHZ_NUM) << srch_ff;
   assign khz_lim    = ctns_pkg::CMP_W'(khz_eff) << 31;
   assign shift_fits = num_shl < khz_lim;

   // One restoring division step.
   assign div_trial    = {rem_ff, quo_ff[ctns_pkg::DATA_W-1]};
   assign div_ge       = div_trial >= {1'b0, dvsr_ff};
   assign div_rem_next = div_ge ? ctns_pkg::DVSR_W'(div_trial - {1'b0, dvsr_ff}) :
                                  ctns_pkg::DVSR_W'(div_trial);
   assign div_quo_next = {quo_ff[ctns_pkg::DATA_W-2:0], div_ge};

   // One shift-add multiplication step; sums wrap at 64 bits.
   assign mul_acc_next = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

   assign ns_divisor = ctns_pkg::DVSR_W'(khz_eff) *
                       ctns_pkg::DVSR_W'(ctns_pkg::HZ_PER_KHZ);

   always_comb begin
      seq_state_in   = seq_state_ff;
      srch_in        = srch_ff;
      step_in        = step_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      dvsr_in        = dvsr_ff;
      acc_in         = acc_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      wrk_mul_in     = wrk_mul_ff;
      wrk_shift_in   = wrk_shift_ff;
      khz_in         = khz_ff;
      ref_in         = ref_ff;
      scale_mul_in   = scale_mul_ff;
      scale_shift_in = scale_shift_ff;
      time_offset_in = time_offset_ff;

      unique case (seq_state_ff)
         ctns_pkg::SEQ_IDLE: begin
         end
         ctns_pkg::SEQ_SEARCH: begin
            // The search always ends by a shift of one for an in-range frequency.
            if (shift_fits || srch_ff == ctns_pkg::SHIFT_W'(1)) begin
               seq_state_in = ctns_pkg::SEQ_DIV_M;
               rem_in       = '0;
               quo_in       = ctns_pkg::DATA_W'(num_shl);
               dvsr_in      = ctns_pkg::DVSR_W'(khz_eff);
               step_in      = '0;
            end else begin
               srch_in = srch_ff - ctns_pkg::SHIFT_W'(1);
            end
         end
         ctns_pkg::SEQ_DIV_M: begin
            rem_in  = div_rem_next;
            quo_in  = div_quo_next;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(ctns_pkg::DIV_STEPS - 1)) begin
               // A shift of 32 is taken as 31 with the multiplier halved.
               if (srch_ff == ctns_pkg::SHIFT_W'(ctns_pkg::MAX_SHIFT)) begin
                  wrk_shift_in = ctns_pkg::SHIFT_W'(ctns_pkg::MAX_SHIFT - 1);
                  wrk_mul_in   = div_quo_next[ctns_pkg::MUL_W:1];
               end else begin
                  wrk_shift_in = srch_ff;
                  wrk_mul_in   = div_quo_next[ctns_pkg::MUL_W-1:0];
               end
               seq_state_in = ctns_pkg::SEQ_MUL_NS;
               acc_in       = '0;
               mcand_in     = ref_ff;
               mplier_in    = ctns_pkg::NS_PER_S;
               step_in      = '0;
            end
         end
         ctns_pkg::SEQ_MUL_NS: begin
            acc_in    = mul_acc_next;
            mcand_in  = {mcand_ff[ctns_pkg::DATA_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[ctns_pkg::MUL_W-1:1]};
            step_in   = step_ff + 6'd1;
            if (step_ff == 6'(ctns_pkg::MUL_STEPS - 1)) begin
               seq_state_in = ctns_pkg::SEQ_DIV_NS;
               rem_in       = '0;
               quo_in       = mul_acc_next;
               dvsr_in      = ns_divisor;
               step_in      = '0;
            end
         end
         ctns_pkg::SEQ_DIV_NS: begin
            rem_in  = div_rem_next;
            quo_in  = div_quo_next;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(ctns_pkg::DIV_STEPS - 1)) begin
               // The quotient now holds the reference time and stays put.
               seq_state_in = ctns_pkg::SEQ_MUL_OFS;
               acc_in       = '0;
               mcand_in     = ref_ff;
               mplier_in    = wrk_mul_ff;
               step_in      = '0;
            end
         end
         ctns_pkg::SEQ_MUL_OFS: begin
            acc_in    = mul_acc_next;
            mcand_in  = {mcand_ff[ctns_pkg::DATA_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[ctns_pkg::MUL_W-1:1]};
            step_in   = step_ff + 6'd1;
            if (step_ff == 6'(ctns_pkg::MUL_STEPS - 1)) begin
               seq_state_in = ctns_pkg::SEQ_COMMIT;
            end
         end
         ctns_pkg::SEQ_COMMIT: begin
            time_offset_in = quo_ff - (acc_ff >> wrk_shift_ff);
            scale_mul_in   = wrk_mul_ff;
            scale_shift_in = wrk_shift_ff;
            seq_state_in   = ctns_pkg::SEQ_IDLE;
         end
         default: begin
            seq_state_in = ctns_pkg::SEQ_IDLE;
         end
      endcase

      // Any register write restarts the derivation from the new values.
      if (csr_wen) begin
         unique case (csr_idx)
            ctns_pkg::REG_COUNTER_KHZ:     khz_in = csr_wdata[ctns_pkg::KHZ_W-1:0];
            ctns_pkg::REG_REFERENCE_COUNT: ref_in = csr_wdata;
            default: begin
            end
         endcase
         seq_state_in = ctns_pkg::SEQ_SEARCH;
         srch_in      = ctns_pkg::SHIFT_W'(ctns_pkg::MAX_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff   <= ctns_pkg::SEQ_IDLE;
         khz_ff         <= ctns_pkg::KHZ_DEFAULT;
         ref_ff         <= '0;
         scale_mul_ff   <= ctns_pkg::MUL_RESET;
         scale_shift_ff <= ctns_pkg::SHIFT_RESET;
         time_offset_ff <= '0;
      end else begin
         seq_state_ff   <= seq_state_in;
         khz_ff         <= khz_in;
         ref_ff         <= ref_in;
         scale_mul_ff   <= scale_mul_in;
         scale_shift_ff <= scale_shift_in;
         time_offset_ff <= time_offset_in;
      end
   end

   always_ff @(posedge clock) begin
      srch_ff      <= srch_in;
      step_ff      <= step_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvsr_ff      <= dvsr_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      wrk_mul_ff   <= wrk_mul_in;
      wrk_shift_ff <= wrk_shift_in;
   end

   // ------------------------------------------------------------------
   // Conversion pipeline.
   // ------------------------------------------------------------------

   // Each stage moves on when it is empty or the stage after it moves on.
   assign adv4 = !rsp_valid_ff || rsp_tready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_tready = adv1 && (seq_state_ff == ctns_pkg::SEQ_IDLE) && !csr_wen;
   assign req_fire   = req_tvalid && req_tready;

   // The upper half only contributes its low 32 bits modulo 2^64.
   assign prod_lo_full = 63'(req_tdata[31:0]) * 63'(scale_mul_ff);
   assign prod_hi_full = 63'(req_tdata[63:32]) * 63'(scale_mul_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_fire;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_fire) begin
         prod_lo_ff <= prod_lo_full;
         prod_hi_ff <= prod_hi_full[31:0];
      end
      if (adv2 && v1_ff) begin
         prod_ff <= {prod_hi_ff, 32'd0} + {1'b0, prod_lo_ff};
      end
      if (adv3 && v2_ff) begin
         scaled_ff <= prod_ff >> scale_shift_ff;
      end
      if (adv4 && v3_ff) begin
         rsp_data_ff <= scaled_ff + time_offset_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The divider's partial remainder never reaches the divisor.
   a_div_rem_below : assert property (@(posedge clock) disable iff (reset)
      (seq_state_ff == ctns_pkg::SEQ_DIV_M || seq_state_ff == ctns_pkg::SEQ_DIV_NS)
      |-> (rem_ff < dvsr_ff))
      else $error("divider remainder not below divisor");

   // The committed shift always lies between one and 31.
   a_shift_range : assert property (@(posedge clock) disable iff (reset)
      (scale_shift_ff >= ctns_pkg::SHIFT_W'(1)) &&
      (scale_shift_ff <= ctns_pkg::SHIFT_W'(ctns_pkg::MAX_SHIFT - 1)))
      else $error("scale shift out of range");

   // An accepted item always occupies the first stage on the next cycle.
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted item lost at pipeline entry");

endmodule

FILE: tb/sv/ns_conversion_checker.sv
`timescale 1ns / 100ps
module ns_conversion_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] cycle_count
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [63:0] nanoseconds
   input  logic        csr_wen,
   input  logic        csr_idx,
   input  logic [63:0] csr_wdata,
   output int          pending_ns,
   output int          mismatches
);

   // Shadow copy of the registers and of the derived scale.
   logic [ctns_pkg::KHZ_W-1:0]   khz_reg;
   logic [ctns_pkg::DATA_W-1:0]  ref_reg;
   logic [ctns_pkg::MUL_W-1:0]   scale_mul;
   logic [ctns_pkg::SHIFT_W-1:0] scale_sh;
   logic [ctns_pkg::DATA_W-1:0]  ns_offset;

   logic [ctns_pkg::DATA_W-1:0]  expected_ns[$];
   logic [ctns_pkg::DATA_W-1:0]  want_ns;

   initial begin
      pending_ns = 0;
      mismatches = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches = mismatches + 1;
   endtask

   // Recomputes multiplier, shift and offset from the shadow registers.
   function automatic void rescale();
      logic [63:0] khz;
      logic [63:0] quot;
      logic [63:0] mul;
      logic [63:0] ns_ref;
      int unsigned sh;
      bit          found;
      khz = 64'(khz_reg);
      if (khz_reg < ctns_pkg::KHZ_LOW || khz_reg > ctns_pkg::KHZ_HIGH) begin
         khz = 64'(ctns_pkg::KHZ_DEFAULT);
      end
      ns_ref = (ref_reg * 64'(ctns_pkg::NS_PER_S)) / (khz * 64'(ctns_pkg::HZ_PER_KHZ));
      found = 1'b0;
      mul = '0;
      sh = 0;
      // The first shift from the top whose quotient stays below 2^31 wins.
      for (int s = ctns_pkg::MAX_SHIFT; s > 0; s--) begin
         quot = (64'(ctns_pkg::KHZ_NUM) << s) / khz;
         if (!found && quot < 64'h8000_0000) begin
            mul = quot;
            sh = s;
            found = 1'b1;
         end
      end
      if (!found) begin
         mul = 64'(ctns_pkg::KHZ_NUM) / khz;
         sh = 0;
      end
      if (sh == 32) begin
         sh = 31;
         mul = mul >> 1;
      end
      scale_mul = mul[ctns_pkg::MUL_W-1:0];
      scale_sh = ctns_pkg::SHIFT_W'(sh);
      ns_offset = ns_ref - ((ref_reg * 64'(scale_mul)) >> scale_sh);
   endfunction

   function automatic logic [63:0] count_to_ns(input logic [63:0] count);
      logic [63:0] product;
      product = count * 64'(scale_mul);
      return ns_offset + (product >> scale_sh);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         khz_reg = ctns_pkg::KHZ_DEFAULT;
         ref_reg = '0;
         scale_mul = ctns_pkg::MUL_RESET;
         scale_sh = ctns_pkg::SHIFT_RESET;
         ns_offset = '0;
         expected_ns.delete();
      end else begin
         // An item taken in the same cycle as a write still sees the old scale.
         if (req_tvalid && req_tready) begin
            expected_ns.push_back(count_to_ns(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_ns.size() == 0) begin
               report_mismatch($sformatf("result %h arrived with nothing outstanding",
                                         rsp_tdata));
            end else begin
               want_ns = expected_ns.pop_front();
               if (rsp_tdata !== want_ns) begin
                  report_mismatch($sformatf("nanoseconds %h, expected %h",
                                            rsp_tdata, want_ns));
               end
            end
         end
         if (csr_wen) begin
            if (csr_idx == ctns_pkg::REG_COUNTER_KHZ) begin
               khz_reg = csr_wdata[ctns_pkg::KHZ_W-1:0];
            end else begin
               ref_reg = csr_wdata;
            end
            rescale();
         end
      end
      pending_ns <= expected_ns.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;

   // Random items per calibration setting; twelve settings give about 450 items.
   localparam int RANDOM_PER_PHASE = 38;
   localparam int PHASES           = 12;
   // The slowest legal run stays far below this even with every stall at its longest.
   localparam int CYCLE_LIMIT      = 500000;
   // The pipeline is four stages deep; this wait covers it with margin.
   localparam int DRAIN_CYCLES     = 12;

   // Every input of the block starts at a known value.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [63:0] cycle_count
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [63:0] nanoseconds
   logic        csr_wen    = 1'b0;
   logic        csr_idx    = ctns_pkg::REG_COUNTER_KHZ;
   logic [63:0] csr_wdata  = '0;

   int pending_ns;
   int mismatches;
   int cycles         = 0;
   int rsp_stall_left = 0;
   bit rsp_calm       = 1'b0;

   always #5 clock = ~clock;

   cycles_to_nanoseconds_scaler_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata)
   );

   ns_conversion_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata),
      .pending_ns (pending_ns),
      .mismatches (mismatches)
   );

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(1, 3);
      end
      if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Counts cluster around the calibration point, as a running counter would, with
   // full-range values, tiny values, single bits and values near the wrap mixed in.
   function automatic logic [63:0] pick_count(input logic [63:0] anchor);
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return anchor + {32'd0, $urandom};
      end
      if (r < 50) begin
         return anchor - 64'($urandom_range(0, 1000));
      end
      if (r < 80) begin
         return {$urandom, $urandom};
      end
      if (r < 88) begin
         return 64'($urandom_range(0, 100000));
      end
      if (r < 94) begin
         return 64'd1 << $urandom_range(0, 63);
      end
      return ~64'd0 - 64'($urandom_range(0, 3));
   endfunction

   // The result side stalls on its own, except in calm stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (!rsp_calm && $urandom_range(0, 99) < 25) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offers one item, after an optional pause, and returns on the edge that takes it.
   // The valid stays high on return so that back-to-back items never drop it.
   task automatic send_item(input logic [63:0] count, input bit calm);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 30) begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= count;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Holds off the sender until every outstanding result has come back. The first
   // edge lets the checker's count catch up with the item taken just now.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_ns != 0) @(posedge clock);
   endtask

   // Writes both registers. Normally each write waits for the derivation it starts;
   // back to back, the second write lands while the first derivation is running.
   task automatic program_scale(input logic [23:0] khz, input logic [63:0] ref_cnt,
                                input bit back_to_back);
      csr_wen <= 1'b1;
      csr_idx <= ctns_pkg::REG_COUNTER_KHZ;
      csr_wdata <= 64'(khz);
      @(posedge clock);
      if (!back_to_back) begin
         csr_wen <= 1'b0;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      csr_wen <= 1'b1;
      csr_idx <= ctns_pkg::REG_REFERENCE_COUNT;
      csr_wdata <= ref_cnt;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [23:0] khz_plan [PHASES];
      logic [63:0] ref_plan [PHASES];
      logic [63:0] directed [9];
      bit          calm;

      // The first setting is the one left by reset. Then come both frequency limits,
      // frequencies below, above and far above the legal range (zero included), the
      // edge where a shift of 32 first fits, and random legal settings.
      khz_plan[0]  = ctns_pkg::KHZ_DEFAULT;        ref_plan[0]  = '0;
      khz_plan[1]  = ctns_pkg::KHZ_LOW;            ref_plan[1]  = '0;
      khz_plan[2]  = ctns_pkg::KHZ_HIGH;           ref_plan[2]  = ~64'd0;
      khz_plan[3]  = 24'd0;                        ref_plan[3]  = {$urandom, $urandom};
      khz_plan[4]  = ctns_pkg::KHZ_LOW - 24'd1;    ref_plan[4]  = {$urandom, $urandom};
      khz_plan[5]  = ctns_pkg::KHZ_HIGH + 24'd1;   ref_plan[5]  = {$urandom, $urandom};
      khz_plan[6]  = 24'hFF_FFFF;                  ref_plan[6]  = {$urandom, $urandom};
      khz_plan[7]  = 24'd2000000;                  ref_plan[7]  = {$urandom, $urandom};
      khz_plan[8]  = 24'd2000001;                  ref_plan[8]  = {$urandom, $urandom};
      khz_plan[9]  = 24'($urandom_range(ctns_pkg::KHZ_LOW, ctns_pkg::KHZ_HIGH));
      ref_plan[9]  = {$urandom, $urandom};
      khz_plan[10] = ctns_pkg::KHZ_DEFAULT;        ref_plan[10] = {$urandom, $urandom};
      khz_plan[11] = 24'($urandom_range(ctns_pkg::KHZ_LOW, ctns_pkg::KHZ_HIGH));
      ref_plan[11] = 64'($urandom_range(0, 1000));

      // Field extremes and patterns where the 64-bit product wraps.
      directed[0] = 64'd0;
      directed[1] = 64'd1;
      directed[2] = ~64'd0;
      directed[3] = 64'h8000_0000_0000_0000;
      directed[4] = 64'h0000_0000_FFFF_FFFF;
      directed[5] = 64'h0000_0001_0000_0000;
      directed[6] = 64'h0000_0004_0000_0000;
      directed[7] = 64'hAAAA_AAAA_AAAA_AAAA;
      directed[8] = 64'h5555_5555_5555_5555;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            // Registers change only with the pipeline empty and settled.
            drain_results();
            repeat (DRAIN_CYCLES) @(posedge clock);
            program_scale(khz_plan[p], ref_plan[p], p == 7);
         end
         calm = ($urandom_range(0, 3) == 0);
         rsp_calm <= ($urandom_range(0, 3) == 0);
         if (p == 0) begin
            foreach (directed[i]) begin
               send_item(directed[i], 1'b0);
            end
         end
         // The calibration count itself must map to its exact nanosecond time.
         send_item(ref_plan[p], calm);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE / 2 && p % 3 == 1) begin
               drain_results();
            end
            send_item(pick_count(ref_plan[p]), calm);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
